// ===== sv/lfu_pkg.sv =====
// lfu_pkg: shared widths, reset values and result field offsets for the lfu page replacement block
// no dependencies; imported by every module of the block

package lfu_pkg;

    // fixed field widths of the item interfaces
    localparam int PAGE_W    = 7;
    localparam int SLOT_W    = 3;
    localparam int FAULT_W   = 16;
    localparam int CFG_W     = 4;

    // defaults for the top level parameters
    localparam int DEF_MAX_FRAMES = 8;
    localparam int DEF_PAGE_COUNT = 128;
    localparam int DEF_COUNT_BITS = 16;

    // reset value of the frames-in-use register
    localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 4'd3;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 8;
    localparam int M_FIELDS_W = 1 + SLOT_W + 1 + PAGE_W + FAULT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // result field offsets in m_tdata
    localparam int OFS_HIT   = 0;
    localparam int OFS_SLOT  = OFS_HIT + 1;
    localparam int OFS_VV    = OFS_SLOT + SLOT_W;
    localparam int OFS_VP    = OFS_VV + 1;
    localparam int OFS_FAULT = OFS_VP + PAGE_W;

    // outcome flags of the frame search
    typedef struct packed {
        logic hit;
        logic victim_valid;
    } sel_flags_t;

endpackage

// ===== sv/lfu_cnt_ram.sv =====
// lfu_cnt_ram: single-port-write, single-port-read count memory with registered read data
// uses lfu_pkg for its parameter defaults

module lfu_cnt_ram
    import lfu_pkg::*;
#(
    parameter int DEPTH  = DEF_PAGE_COUNT,
    parameter int ADDR_W = $clog2(DEF_PAGE_COUNT),
    parameter int DATA_W = DEF_COUNT_BITS
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lfu_frame_sel.sv =====
// lfu_frame_sel: hit lookup, first empty frame and least-count victim search over the frames
// depends on lfu_pkg for widths and the sel_flags_t result struct

module lfu_frame_sel
    import lfu_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int FIDX_W     = (DEF_MAX_FRAMES > 1) ? $clog2(DEF_MAX_FRAMES) : 1
) (
    input  logic [PAGE_W-1:0]     page_i,
    input  logic [PAGE_W-1:0]     frame_page_i [MAX_FRAMES],
    input  logic [MAX_FRAMES-1:0] frame_occ_i,
    input  logic [COUNT_BITS-1:0] frame_cnt_i [MAX_FRAMES],
    input  logic [MAX_FRAMES-1:0] active_i,
    output sel_flags_t            flags_o,
    output logic [FIDX_W-1:0]     slot_o,
    output logic [PAGE_W-1:0]     victim_page_o
);

    localparam int LVL   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 0;
    localparam int NP    = 1 << LVL;
    localparam int NODES = 2 * NP - 1;

    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] empty;
    logic [FIDX_W-1:0]     hit_slot;
    logic [FIDX_W-1:0]     empty_slot;
    logic [FIDX_W-1:0]     min_slot;

    logic [COUNT_BITS-1:0] leaf_cnt [NP];
    logic                  leaf_vld [NP];
    logic [COUNT_BITS-1:0] t_cnt [NODES];
    logic [FIDX_W-1:0]     t_idx [NODES];
    logic                  t_vld [NODES];

    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            match[i] = active_i[i] && frame_occ_i[i] && (frame_page_i[i] == page_i);
            empty[i] = active_i[i] && !frame_occ_i[i];
        end
    end

    // lowest set index wins
    always_comb begin
        hit_slot   = '0;
        empty_slot = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_slot = FIDX_W'(i);
            end
            if (empty[i]) begin
                empty_slot = FIDX_W'(i);
            end
        end
    end

    // leaves padded up to a power of two
    for (genvar gi = 0; gi < NP; gi++) begin : g_leaf
        if (gi < MAX_FRAMES) begin : g_real
            assign leaf_cnt[gi] = frame_cnt_i[gi];
            assign leaf_vld[gi] = active_i[gi];
        end else begin : g_pad
            assign leaf_cnt[gi] = '0;
            assign leaf_vld[gi] = 1'b0;
        end
    end

    // min tree, left child kept on a tie so the lower index wins
    always_comb begin
        logic take_l;
        for (int i = 0; i < NP; i++) begin
            t_cnt[NP-1+i] = leaf_cnt[i];
            t_idx[NP-1+i] = FIDX_W'(i);
            t_vld[NP-1+i] = leaf_vld[i];
        end
        for (int k = NP - 2; k >= 0; k--) begin
            take_l = t_vld[2*k+1] && (!t_vld[2*k+2] || (t_cnt[2*k+1] <= t_cnt[2*k+2]));
            t_cnt[k] = take_l ? t_cnt[2*k+1] : t_cnt[2*k+2];
            t_idx[k] = take_l ? t_idx[2*k+1] : t_idx[2*k+2];
            t_vld[k] = t_vld[2*k+1] || t_vld[2*k+2];
        end
        min_slot = t_idx[0];
    end

    always_comb begin
        flags_o       = '0;
        slot_o        = '0;
        victim_page_o = '0;
        priority if (|match) begin
            flags_o.hit = 1'b1;
            slot_o      = hit_slot;
        end else if (|empty) begin
            slot_o = empty_slot;
        end else begin
            flags_o.victim_valid = 1'b1;
            slot_o               = min_slot;
            victim_page_o        = frame_page_i[min_slot];
        end
    end

endmodule

// ===== sv/lfu_page_replacement.sv =====
// lfu_page_replacement: top level of the lfu page replacement block
// depends on lfu_pkg, lfu_cnt_ram and lfu_frame_sel

// usage
//   s_ channel: one page reference per item, page number in s_tdata[6:0]
//   m_ channel: one result per reference (hit, frame slot, victim, fault total)
//   cfg_we / cfg_wdata: writes the frames-in-use register (0 acts as 1, values above
//   MAX_FRAMES act as MAX_FRAMES); write only while no item is in flight
// timing
//   the accept edge reads the item's count from the count memory; the write-back edge
//   writes the incremented count back and loads the result register, waiting while a
//   finished result is still held; no new item is accepted before that write-back,
//   set by the read-modify-write of the single count memory; m_tvalid rises at the
//   write-back edge
// reset
//   aresetn low empties all frames, zeroes the fault counter and sets frames-in-use
//   to 3; afterwards a clearing pass zeroes the count memory one entry per cycle,
//   all PAGE_COUNT entries (128 by default), with s_tready held low
// back-pressure
//   the result register holds while m_tready is low; one more item may be accepted
//   and waits in the write-back step until the result register frees up

module lfu_page_replacement
    import lfu_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int PAGE_COUNT = DEF_PAGE_COUNT,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // frames-in-use register write
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // page reference items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [6:0] page_number, [7] zero
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [0] hit, [3:1] frame_slot, [4] victim_valid,
                                            // [11:5] victim_page, [27:12] fault_total,
                                            // [31:28] zero
);

    localparam int ADDR_W  = $clog2(PAGE_COUNT);
    localparam int FIDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NCNT_W  = ($clog2(MAX_FRAMES + 1) > CFG_W) ? $clog2(MAX_FRAMES + 1) : CFG_W;
    localparam int PAGES_W = 1 << PAGE_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // control state
    state_t                state_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [CFG_W-1:0]      frames_reg;
    logic [FAULT_W-1:0]    fault_reg;
    logic                  m_tvalid_reg;

    // frame table: page, count-entry key and a shadow of that entry's count
    logic [PAGE_W-1:0]     frame_page_reg [MAX_FRAMES];
    logic [ADDR_W-1:0]     frame_key_reg  [MAX_FRAMES];
    logic [COUNT_BITS-1:0] frame_cnt_reg  [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] frame_occ_reg;

    // item in flight and result payload
    logic [PAGE_W-1:0]     page_reg;
    logic [ADDR_W-1:0]     key_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [ADDR_W-1:0]     key_tbl [PAGES_W];
    logic [PAGE_W-1:0]     s_page;
    logic [ADDR_W-1:0]     s_key;
    logic                  accept;
    logic                  exec_go;

    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [COUNT_BITS-1:0] ram_wr_data;
    logic [COUNT_BITS-1:0] ram_rd_data;
    logic [COUNT_BITS-1:0] cnt_new;

    logic [NCNT_W-1:0]     fiu_ext;
    logic [NCNT_W-1:0]     n_active;
    logic [MAX_FRAMES-1:0] active;
    logic [COUNT_BITS-1:0] eff_cnt [MAX_FRAMES];

    sel_flags_t            sel_flags;
    logic [FIDX_W-1:0]     sel_slot;
    logic [PAGE_W-1:0]     sel_victim;

    logic [FAULT_W-1:0]        fault_next;
    logic [FIDX_W+SLOT_W-1:0]  slot_wide;
    logic [M_TDATA_W-1:0]      m_tdata_next;

    // page number to count entry, folded modulo PAGE_COUNT at elaboration
    for (genvar gp = 0; gp < PAGES_W; gp++) begin : g_key
        assign key_tbl[gp] = ADDR_W'(gp % PAGE_COUNT);
    end

    assign s_page   = s_tdata[PAGE_W-1:0];
    assign s_key    = key_tbl[s_page];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // write-back waits only while a finished result is still held
    assign exec_go  = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

    // saturating increment of the count read on the accept edge
    assign cnt_new = (&ram_rd_data) ? ram_rd_data : ram_rd_data + COUNT_BITS'(1);

    // clearing pass and write-back share the memory write port
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = key_reg;
        ram_wr_data = cnt_new;
        if (state_reg == ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = '0;
        end else if (exec_go) begin
            ram_wr_en = 1'b1;
        end
    end

    lfu_cnt_ram #(
        .DEPTH  (PAGE_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_BITS)
    ) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (s_key),
        .rd_data (ram_rd_data)
    );

    // active frame count, clamped to 1..MAX_FRAMES
    assign fiu_ext = NCNT_W'(frames_reg);

    always_comb begin
        priority if (fiu_ext == '0) begin
            n_active = NCNT_W'(1);
        end else if (fiu_ext > NCNT_W'(MAX_FRAMES)) begin
            n_active = NCNT_W'(MAX_FRAMES);
        end else begin
            n_active = fiu_ext;
        end
    end

    // counts as seen after this reference: frames sharing its entry take the new value
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            active[i]  = NCNT_W'(i) < n_active;
            eff_cnt[i] = (frame_key_reg[i] == key_reg) ? cnt_new : frame_cnt_reg[i];
        end
    end

    lfu_frame_sel #(
        .MAX_FRAMES (MAX_FRAMES),
        .COUNT_BITS (COUNT_BITS),
        .FIDX_W     (FIDX_W)
    ) u_frame_sel (
        .page_i        (page_reg),
        .frame_page_i  (frame_page_reg),
        .frame_occ_i   (frame_occ_reg),
        .frame_cnt_i   (eff_cnt),
        .active_i      (active),
        .flags_o       (sel_flags),
        .slot_o        (sel_slot),
        .victim_page_o (sel_victim)
    );

    // every miss counts as a fault, saturating
    always_comb begin
        fault_next = fault_reg;
        if (!sel_flags.hit && !(&fault_reg)) begin
            fault_next = fault_reg + FAULT_W'(1);
        end
    end

    assign slot_wide    = (FIDX_W + SLOT_W)'(sel_slot);
    assign m_tdata_next = M_TDATA_W'({fault_next, sel_victim, sel_flags.victim_valid,
                                      slot_wide[SLOT_W-1:0], sel_flags.hit});

    // control, frame table and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            frames_reg    <= CFG_FRAMES_RESET;
            fault_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            frame_occ_reg <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                frame_page_reg[i] <= '0;
                frame_key_reg[i]  <= '0;
                frame_cnt_reg[i]  <= '0;
            end
        end else begin
            if (cfg_we) begin
                frames_reg <= cfg_wdata;
            end
            // a write-back in the same cycle reloads the valid below
            if (m_tvalid_reg && m_tready && !exec_go) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    if (clr_addr_reg == ADDR_W'(PAGE_COUNT - 1)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (exec_go) begin
                        state_reg    <= ST_IDLE;
                        m_tvalid_reg <= 1'b1;
                        fault_reg    <= fault_next;
                        for (int i = 0; i < MAX_FRAMES; i++) begin
                            if (!sel_flags.hit && (sel_slot == FIDX_W'(i))) begin
                                // placement into an empty frame or over the victim
                                frame_page_reg[i] <= page_reg;
                                frame_key_reg[i]  <= key_reg;
                                frame_cnt_reg[i]  <= cnt_new;
                                frame_occ_reg[i]  <= 1'b1;
                            end else if (frame_key_reg[i] == key_reg) begin
                                frame_cnt_reg[i] <= cnt_new;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            page_reg <= s_page;
            key_reg  <= s_key;
        end
        if (exec_go) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/lfu_chk.sv =====
// lfu_chk: port-level checker for lfu_page_replacement, with its bind statement
// depends on lfu_pkg for stream widths and result field offsets

module lfu_chk
    import lfu_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in back-to-back cycles");

    // reset starts the count clearing pass with input closed
    a_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // a hit never reports a victim
    a_hit_novictim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OFS_HIT] |->
            !m_tdata[OFS_VV] && (m_tdata[OFS_VP +: PAGE_W] == '0))
        else $error("victim reported on a hit");

    // a fresh result rises only after a matching accept
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without matching accept");

endmodule

bind lfu_page_replacement lfu_chk u_lfu_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/lfu_page_replacement_test.sv =====
// lfu_page_replacement_test: self-checking bench for the lfu page replacement block
// streams page references, predicts hit, slot, victim and fault total per item, checks each result
// depends on lfu_pkg and lfu_page_replacement

module lfu_page_replacement_test;
    import lfu_pkg::*;

    localparam int FRAMES      = DEF_MAX_FRAMES;
    localparam int PAGES       = DEF_PAGE_COUNT;
    localparam int STALL_LIMIT = 2000;   // idle cycles before the run is declared hung
    localparam int DRAIN_WAIT  = 4;      // extra settle wait after the last result
    localparam int HAMMER_RUN  = 40;     // references in each long directed run
    localparam int RANDOM_ITEMS = 950;   // references in the random phases

    // one expected result item
    typedef struct {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               victim_valid;
        logic [PAGE_W-1:0]  victim_page;
        logic [FAULT_W-1:0] fault_total;
    } lfu_result_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // block ports
    logic                 cfg_we    = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [6:0] page_number, [7] zero
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [0] hit, [3:1] frame_slot, [4] victim_valid,
                                            // [11:5] victim_page, [27:12] fault_total

    lfu_page_replacement DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predictor state, mirrors the block after every accepted reference
    logic [CFG_W-1:0]          frames_cfg;
    logic [PAGE_W-1:0]         frame_page [FRAMES];
    logic                      frame_full [FRAMES];
    logic [DEF_COUNT_BITS-1:0] ref_tally  [PAGES];
    logic [FAULT_W-1:0]        fault_tally;

    lfu_result_t expected_results [$];

    // run bookkeeping
    int failures         = 0;
    int items_sent       = 0;
    int hits_predicted   = 0;
    int evicts_predicted = 0;
    int settings_written = 0;
    int stall_cycles     = 0;
    bit steady           = 1'b0;   // both sides run without gaps while set

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    task automatic reset_predictor();
        frames_cfg  = CFG_FRAMES_RESET;
        fault_tally = '0;
        for (int i = 0; i < FRAMES; i++) begin
            frame_page[i] = '0;
            frame_full[i] = 1'b0;
        end
        for (int p = 0; p < PAGES; p++) ref_tally[p] = '0;
    endtask

    // active frame count: zero acts as one, anything above the frame count is clipped
    function automatic int active_frames(logic [CFG_W-1:0] cfg);
        int n;
        n = int'(cfg);
        if (n < 1) n = 1;
        if (n > FRAMES) n = FRAMES;
        return n;
    endfunction

    function automatic lfu_result_t predict_reference(logic [PAGE_W-1:0] pg);
        lfu_result_t             r;
        int                      n;
        int                      slot;
        bit                      placed;
        logic [DEF_COUNT_BITS-1:0] least;
        n      = active_frames(frames_cfg);
        slot   = 0;
        placed = 1'b0;
        r.hit          = 1'b0;
        r.victim_valid = 1'b0;
        r.victim_page  = '0;

        // count first, saturating
        if (ref_tally[pg % PAGES] != '1) ref_tally[pg % PAGES]++;

        // hit search, lowest active frame wins
        for (int i = 0; i < n; i++) begin
            if (!r.hit && frame_full[i] && frame_page[i] == pg) begin
                r.hit = 1'b1;
                slot  = i;
            end
        end

        if (!r.hit) begin
            // lowest empty active frame
            for (int i = 0; i < n; i++) begin
                if (!placed && !frame_full[i]) begin
                    slot   = i;
                    placed = 1'b1;
                end
            end
            // no empty frame: least count, ties to the lowest index
            if (!placed) begin
                least = ref_tally[frame_page[0] % PAGES];
                slot  = 0;
                for (int i = 1; i < n; i++) begin
                    if (ref_tally[frame_page[i] % PAGES] < least) begin
                        least = ref_tally[frame_page[i] % PAGES];
                        slot  = i;
                    end
                end
                r.victim_valid = 1'b1;
                r.victim_page  = frame_page[slot];
            end
            frame_page[slot] = pg;
            frame_full[slot] = 1'b1;
            if (fault_tally != '1) fault_tally++;
        end

        r.slot        = slot[SLOT_W-1:0];
        r.fault_total = fault_tally;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // idle cycles before the next item, zero at least half the time
    function automatic int draw_gap();
        if (steady) return 0;
        if ($urandom_range(0, 1) == 0) return 0;
        return int'($urandom_range(0, 16));
    endfunction

    // send one page reference and record what it should produce
    task automatic send_page(input logic [PAGE_W-1:0] pg);
        int          gap;
        lfu_result_t r;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pg};
        do @(posedge aclk); while (!(s_tready === 1'b1));
        // accepted at this edge
        r = predict_reference(pg);
        expected_results.push_back(r);
        items_sent++;
        if (r.hit) hits_predicted++;
        if (r.victim_valid) evicts_predicted++;
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // hold the sender until every expected result is back, then let the pipe settle
    task automatic wait_drained();
        idle_sender();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // frames-in-use write, only with nothing in flight
    task automatic write_frames(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        frames_cfg = value;
        settings_written++;
    endtask

    // ---------------------------------------------------------------
    // result side: ready pattern and checking
    // ---------------------------------------------------------------

    initial begin : result_ready
        int gap;
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_tvalid === 1'b1));
        end
    end

    always @(posedge aclk) begin : result_check
        lfu_result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result item with no reference outstanding: m_tdata %h", m_tdata);
                failures++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[OFS_HIT] !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, m_tdata[OFS_HIT]);
                    failures++;
                end
                if (m_tdata[OFS_SLOT +: SLOT_W] !== want.slot) begin
                    $error("frame_slot: expected %0d, got %0d",
                           want.slot, m_tdata[OFS_SLOT +: SLOT_W]);
                    failures++;
                end
                if (m_tdata[OFS_VV] !== want.victim_valid) begin
                    $error("victim_valid: expected %0d, got %0d",
                           want.victim_valid, m_tdata[OFS_VV]);
                    failures++;
                end
                if (m_tdata[OFS_VP +: PAGE_W] !== want.victim_page) begin
                    $error("victim_page: expected %0d, got %0d",
                           want.victim_page, m_tdata[OFS_VP +: PAGE_W]);
                    failures++;
                end
                if (m_tdata[OFS_FAULT +: FAULT_W] !== want.fault_total) begin
                    $error("fault_total: expected %0d, got %0d",
                           want.fault_total, m_tdata[OFS_FAULT +: FAULT_W]);
                    failures++;
                end
            end
        end
    end

    // watchdog: any accepted item on either side restarts the count
    always @(posedge aclk) begin : stall_watch
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no item moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_results.size());
            $display("** lfu_page_replacement: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset value of three frames: fill, hit, least-count eviction, tie to lowest frame
    task automatic test_reset_defaults();
        send_page(7'd0);
        send_page(7'd127);
        send_page(7'd5);
        send_page(7'd0);      // hit
        send_page(7'd42);     // 127 and 5 tie, frame 1 goes
        send_page(7'd127);    // comes back, evicts least
        send_page(7'd0);      // hit on a well-used page
    endtask

    // register extremes: zero acts as one frame, 15 as all frames, idle frames keep pages
    task automatic test_frame_limits();
        write_frames(4'd0);
        send_page(7'd3);
        send_page(7'd3);
        send_page(7'd9);
        write_frames(4'd15);
        for (int p = 60; p < 65; p++) send_page(p[PAGE_W-1:0]);
        send_page(7'd127);
        write_frames(4'd2);
        send_page(7'd62);     // lives in an inactive frame, so a fault here
        write_frames(4'd8);
        send_page(7'd62);     // now resident twice, lowest frame reports
        send_page(7'd63);
        write_frames(4'd1);
        send_page(7'd0);
    endtask

    // phases of random settings; most traffic circles a small working set so
    // hits and evictions dominate, the rest is spread over all pages
    task automatic test_random_traffic(input int total);
        int               sent;
        int               len;
        int               pool_base;
        int               pool_size;
        logic [CFG_W-1:0] cfg;
        logic [PAGE_W-1:0] pg;
        sent = 0;
        while (sent < total) begin
            if ($urandom_range(0, 3) == 0) cfg = CFG_W'($urandom_range(0, 15));
            else                           cfg = CFG_W'($urandom_range(1, FRAMES));
            write_frames(cfg);
            steady    = ($urandom_range(0, 4) == 0);
            len       = int'($urandom_range(20, 100));
            pool_base = int'($urandom_range(0, PAGES - 1));
            pool_size = active_frames(cfg) + int'($urandom_range(0, 4));
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 4) == 0)
                    pg = PAGE_W'($urandom_range(0, PAGES - 1));
                else
                    pg = PAGE_W'((pool_base + int'($urandom_range(0, pool_size - 1))) % PAGES);
                send_page(pg);
                if ($urandom_range(0, 63) == 0) wait_drained();
            end
            steady = 1'b0;
            sent += len;
        end
    endtask

    // one page referenced far more than the others must never look cheapest
    task automatic test_heavy_page();
        write_frames(4'd2);
        steady = 1'b1;
        for (int k = 0; k < HAMMER_RUN; k++) send_page(7'd100);
        steady = 1'b0;
        for (int k = 0; k < 12; k++) send_page(k[0] ? 7'd100 : 7'(101 + k));
    endtask

    // one frame, two pages in turn: every item faults and evicts the page held before it
    task automatic test_fault_run();
        write_frames(4'd1);
        steady = 1'b1;
        for (int k = 0; k < HAMMER_RUN; k++) send_page(k[0] ? 7'd21 : 7'd20);
        steady = 1'b0;
        write_frames(4'd8);
        for (int k = 0; k < 12; k++) send_page(PAGE_W'($urandom_range(0, PAGES - 1)));
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        reset_predictor();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_frame_limits();
        test_random_traffic(RANDOM_ITEMS);
        test_heavy_page();
        test_fault_run();

        idle_sender();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT * 2) @(posedge aclk);

        $display("sent %0d page references over %0d frame settings: %0d hits, %0d evictions",
                 items_sent, settings_written, hits_predicted, evicts_predicted);
        $display("covered frame-count extremes, ties, a heavily used page and a long fault run");
        if (failures == 0 && expected_results.size() == 0)
            $display("** lfu_page_replacement: PASSED **");
        else
            $display("** lfu_page_replacement: FAILED **");
        $finish;
    end

endmodule
